/* rtl/rau_pkg.sv */
// Shared types and constants of the rational arithmetic unit.
package rau_pkg;
    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FIELD_W = 32;
    localparam int MAG_W   = 64;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]        command;
        logic [FIELD_W-1:0] a_num;
        logic [FIELD_W-1:0] a_den;
        logic [FIELD_W-1:0] b_num;
        logic [FIELD_W-1:0] b_den;
    } t_in_word;

    typedef struct packed {
        logic [63:0] res_num;
        logic [62:0] res_den;
        logic        zero_den_error;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_LOAD, OP_MUL1, OP_MUL2, OP_COMBINE, OP_GCD_INIT, OP_GCD_STEP,
        OP_DIV_INIT, OP_DIV_STEP, OP_DIV2_INIT, OP_FINISH, OP_NONE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
    } t_dp_status;
endpackage

/* rtl/rau_if.sv */
// Valid/ready channel interface carrying one word.
interface rau_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit.
// The block takes one word on the input channel: an operation code and two
// signed fractions. It returns one word on the output channel: the reduced
// numerator, the nonnegative reduced denominator and a zero-denominator flag.
// Work per word: the cross products and their combination, then one binary
// gcd step per cycle over 64-bit magnitudes, then two restoring divisions
// by the gcd at one quotient bit per cycle.
// The time per word is set by the gcd loop and the shared divider; one word
// is in flight at a time.
// The input is ready only while the block is idle. The result is held on the
// output channel until the receiver takes it; while it stalls, no new word
// is accepted. The synchronous reset returns the controller to idle; the
// datapath registers are not reset.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_if.sink   i_in,
    rau_if.source o_out
);
    t_dp_cmd    cmd;
    t_dp_status status;
    t_in_word   in_word;
    t_out_word  out_word;

    assign in_word    = i_in.data;
    assign o_out.data = out_word;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_word  (in_word),
        .o_status(status),
        .o_result(out_word)
    );
endmodule

/* rtl/rau_datapath.sv */
// Datapath: sign-magnitude products, binary gcd and restoring division.
module rau_datapath
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic       i_clk,
    input  t_dp_cmd    i_cmd,
    input  t_in_word   i_word,
    output t_dp_status o_status,
    output t_out_word  o_result
);
    localparam int OW = OPERAND_WIDTH;
    localparam int SH_W = $clog2(MAG_W + 1);

    logic [OW-1:0] r_mag [4];
    logic [3:0]    r_neg;
    logic [1:0]    r_op;
    logic [MAG_W-1:0] r_p0, r_p1, r_p2;
    logic [2:0]    r_pn;
    logic [MAG_W-1:0] r_n, r_d;
    logic          r_nn, r_dn;
    logic [MAG_W-1:0] r_x, r_y;
    logic [SH_W-1:0]  r_k;
    logic [MAG_W-1:0] r_g;
    logic [MAG_W-1:0] r_q, r_rem, r_rn;
    logic [6:0]       r_cnt;
    logic             r_second;
    logic [MAG_W-1:0] r_rd;

    logic [OW-1:0] in_raw [4];
    logic [MAG_W-1:0] n_sum, n_diff;
    logic          sneg;
    logic [MAG_W-1:0] rem_sh;

    assign in_raw[0] = i_word.a_num[OW-1:0];
    assign in_raw[1] = i_word.a_den[OW-1:0];
    assign in_raw[2] = i_word.b_num[OW-1:0];
    assign in_raw[3] = i_word.b_den[OW-1:0];

    always_comb begin
        sneg   = r_pn[1] ^ (r_op == CMD_SUB);
        n_sum  = r_p0 + r_p1;
        n_diff = (r_p0 >= r_p1) ? r_p0 - r_p1 : r_p1 - r_p0;
        rem_sh = {r_rem[MAG_W-2:0], r_q[MAG_W-1]};
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_op <= i_word.command;
                for (int i = 0; i < 4; i++) begin
                    r_neg[i] <= in_raw[i][OW-1];
                    r_mag[i] <= in_raw[i][OW-1] ? (~in_raw[i] + 1'b1) : in_raw[i];
                end
            end
            OP_MUL1: begin
                // an*bd (or an*bn for multiply) and ad*bn; the ad*bd product follows
                if (r_op == CMD_MUL) begin
                    r_p0 <= MAG_W'(r_mag[0]) * MAG_W'(r_mag[2]);
                    r_pn[0] <= r_neg[0] ^ r_neg[2];
                end else begin
                    r_p0 <= MAG_W'(r_mag[0]) * MAG_W'(r_mag[3]);
                    r_pn[0] <= r_neg[0] ^ r_neg[3];
                end
                r_p1 <= MAG_W'(r_mag[1]) * MAG_W'(r_mag[2]);
                r_pn[1] <= r_neg[1] ^ r_neg[2];
            end
            OP_MUL2: begin
                r_p2 <= MAG_W'(r_mag[1]) * MAG_W'(r_mag[3]);
                r_pn[2] <= r_neg[1] ^ r_neg[3];
            end
            OP_COMBINE: begin
                if (r_op == CMD_MUL) begin
                    r_n <= r_p0; r_nn <= r_pn[0] && (r_p0 != '0);
                    r_d <= r_p2; r_dn <= r_pn[2] && (r_p2 != '0);
                end else if (r_op == CMD_DIV) begin
                    r_n <= r_p0; r_nn <= r_pn[0] && (r_p0 != '0);
                    r_d <= r_p1; r_dn <= r_pn[1] && (r_p1 != '0);
                end else begin
                    r_d <= r_p2; r_dn <= r_pn[2] && (r_p2 != '0);
                    if (r_p1 == '0) begin
                        r_n <= r_p0; r_nn <= r_pn[0] && (r_p0 != '0);
                    end else if (r_p0 == '0) begin
                        r_n <= r_p1; r_nn <= sneg;
                    end else if (r_pn[0] == sneg) begin
                        r_n <= n_sum; r_nn <= sneg;
                    end else begin
                        r_n <= n_diff;
                        r_nn <= ((r_p0 >= r_p1) ? r_pn[0] : sneg) && (n_diff != '0);
                    end
                end
            end
            OP_GCD_INIT: begin
                r_x <= r_n;
                r_y <= r_d;
                r_k <= '0;
            end
            OP_GCD_STEP: begin
                if (r_x == '0 || r_y == '0) begin
                    r_g <= (r_x | r_y) << r_k;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1; r_y <= r_y >> 1; r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= (r_x - r_y) >> 1;
                end else begin
                    r_y <= (r_y - r_x) >> 1;
                end
            end
            OP_DIV_INIT, OP_DIV2_INIT: begin
                r_second <= (i_cmd.op == OP_DIV2_INIT);
                r_q   <= (i_cmd.op == OP_DIV2_INIT) ? r_d : r_n;
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV_STEP: begin
                if (rem_sh >= r_g) begin
                    r_rem <= rem_sh - r_g;
                    r_q   <= {r_q[MAG_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[MAG_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 7'(MAG_W - 1)) begin
                    if (r_second) r_rd <= {r_q[MAG_W-2:0], rem_sh >= r_g};
                    else          r_rn <= {r_q[MAG_W-2:0], rem_sh >= r_g};
                end
            end
            default: ;
        endcase
    end

    logic       neg;
    logic       err;
    logic [MAG_W-1:0] rn_v, rd_v;
    always_comb begin
        err  = (r_d == '0);
        rn_v = (r_g == '0) ? '0 : r_rn;
        rd_v = (r_g == '0) ? '0 : r_rd;
        neg  = (r_g != '0) && (rn_v != '0) && (err ? r_nn : (r_nn ^ r_dn));
        o_result.zero_den_error = err;
        o_result.res_den = rd_v[62:0];
        if (neg)                 o_result.res_num = ~rn_v + 1'b1;
        else if (rn_v[MAG_W-1])  o_result.res_num = {1'b0, {(MAG_W-1){1'b1}}};
        else                     o_result.res_num = rn_v;
        o_status.gcd_done = (r_x == '0) || (r_y == '0);
        o_status.div_done = (r_cnt == 7'(MAG_W - 1));
    end
endmodule

/* rtl/rau_ctrl.sv */
// Controller sequencing load, products, gcd, divisions and output.
module rau_ctrl
    import rau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GINIT, S_GCD, S_D1I, S_D1,
        S_D2I, S_D2, S_FIN, S_OUT
    } t_state;

    t_state r_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_MUL1:  o_cmd.op = OP_MUL1;
            S_MUL2:  o_cmd.op = OP_MUL2;
            S_COMB:  o_cmd.op = OP_COMBINE;
            S_GINIT: o_cmd.op = OP_GCD_INIT;
            S_GCD:   o_cmd.op = OP_GCD_STEP;
            S_D1I:   o_cmd.op = OP_DIV_INIT;
            S_D1:    o_cmd.op = OP_DIV_STEP;
            S_D2I:   o_cmd.op = OP_DIV2_INIT;
            S_D2:    o_cmd.op = OP_DIV_STEP;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_MUL1;
                S_MUL1:  r_state <= S_MUL2;
                S_MUL2:  r_state <= S_COMB;
                S_COMB:  r_state <= S_GINIT;
                S_GINIT: r_state <= S_GCD;
                S_GCD:   if (i_status.gcd_done) r_state <= S_D1I;
                S_D1I:   r_state <= S_D1;
                S_D1:    if (i_status.div_done) r_state <= S_D2I;
                S_D2I:   r_state <= S_D2;
                S_D2:    if (i_status.div_done) r_state <= S_FIN;
                S_FIN:   r_state <= S_OUT;
                S_OUT:   if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/rau_checker.sv */
// Port-level checker for the rational arithmetic unit, with its bind.
module rau_checker
    import rau_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_data
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready) else $error("accepted twice");
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_data.res_den == '0) == i_out_data.zero_den_error))
        else $error("denominator and error flag disagree");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_data (o_out.data)
);
